[src/assert_macros.svh]
// Assertion macros for the debounce and press classifier core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define BDPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included
`define BDPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/bdpc_pkg.sv]
// Shared types, codes and defaults of the button debounce and press classifier
package bdpc_pkg;

   localparam int TIME_BITS_DEFAULT = 32;

   // operation codes
   localparam logic [1:0] FUNC_UPDATE = 2'd0;
   localparam logic [1:0] FUNC_TAKE   = 2'd1;
   localparam logic [1:0] FUNC_INIT   = 2'd2;

   // event bits
   localparam logic [3:0] EV_NONE     = 4'b0000;
   localparam logic [3:0] EV_PRESSED  = 4'b0001;
   localparam logic [3:0] EV_RELEASED = 4'b0010;
   localparam logic [3:0] EV_SHORT    = 4'b0100;
   localparam logic [3:0] EV_LONG     = 4'b1000;

   // status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NOT_INIT = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_PRESSED = 2'd2;

   // configuration reset values
   localparam logic [15:0] DEBOUNCE_RESET    = 16'd20;
   localparam logic [15:0] LONG_PRESS_RESET  = 16'd1000;
   localparam logic        LOW_PRESSED_RESET = 1'b1;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic        low_pressed;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic        pin_level;
      logic [31:0] now_ms;
      logic [3:0]  take_mask;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic        is_pressed;
      logic        raw_pressed_now;
      logic [3:0]  new_events;
      logic [3:0]  pending_out;
      logic [3:0]  taken_events;
      logic [31:0] hold_duration;
   } rsp_item_type;

endpackage

[src/bdpc_req_if.sv]
// Request channel: operation, pin sample, timestamp and take mask
interface bdpc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic        pin_level;
   logic [31:0] now_ms;
   logic [3:0]  take_mask;

   modport source (output valid, func, pin_level, now_ms, take_mask, input ready);
   modport sink   (input valid, func, pin_level, now_ms, take_mask, output ready);
endinterface

[src/bdpc_rsp_if.sv]
// Response channel: status, debounced state, events and hold duration
interface bdpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        is_pressed;
   logic        raw_pressed_now;
   logic [3:0]  new_events;
   logic [3:0]  pending_out;
   logic [3:0]  taken_events;
   logic [31:0] hold_duration;

   modport source (output valid, status, is_pressed, raw_pressed_now, new_events,
                   pending_out, taken_events, hold_duration, input ready);
   modport sink   (input valid, status, is_pressed, raw_pressed_now, new_events,
                   pending_out, taken_events, hold_duration, output ready);
endinterface

[src/bdpc_csr_if.sv]
// Configuration write channel: register index and write data
interface bdpc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bdpc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [bdpc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/bdpc_csr.sv]
// Configuration registers: debounce time, long press time, polarity
module bdpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_valid,
   input  logic [bdpc_pkg::CSR_INDEX_BITS-1:0] wr_index,
   input  logic [bdpc_pkg::CSR_DATA_BITS-1:0]  wr_data,
   output logic                                wr_ready,
   output bdpc_pkg::cfg_type                   cfg
);

   bdpc_pkg::cfg_type cfg_ff;
   bdpc_pkg::cfg_type cfg_in;

   // take a beat every cycle
   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   // decode the write; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            bdpc_pkg::CSR_DEBOUNCE:    cfg_in.debounce_time   = wr_data;
            bdpc_pkg::CSR_LONG_PRESS:  cfg_in.long_press_time = wr_data;
            bdpc_pkg::CSR_LOW_PRESSED: cfg_in.low_pressed     = wr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= bdpc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_time <= bdpc_pkg::LONG_PRESS_RESET;
         cfg_ff.low_pressed     <= bdpc_pkg::LOW_PRESSED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/bdpc_core.sv]
// Debounce state, press timing, event latch and result register
`include "assert_macros.svh"

module bdpc_core #(
   parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bdpc_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   input  bdpc_pkg::req_item_type in_item,
   output logic                   in_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bdpc_pkg::rsp_item_type rsp_item
);

   // state
   logic                 ready_ff,  ready_in;
   logic                 stable_ff, stable_in;
   logic                 last_raw_ff, last_raw_in;
   logic                 timing_ff, timing_in;
   logic                 long_ff,   long_in;
   logic [TIME_BITS-1:0] change_ff, change_in;
   logic [TIME_BITS-1:0] start_ff,  start_in;
   logic [TIME_BITS-1:0] dur_ff,    dur_in;
   logic [3:0]           pending_ff, pending_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   bdpc_pkg::rsp_item_type rsp_item_ff,  rsp_item_in;

   logic                 fire;
   logic                 raw;
   logic                 raw_chg;
   logic                 arm;
   logic                 ld_eff;
   logic                 flip;
   logic                 is_long;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] db_t;
   logic [TIME_BITS-1:0] lp_t;
   logic [TIME_BITS-1:0] chg_diff;
   logic [TIME_BITS-1:0] start_eff;
   logic [TIME_BITS-1:0] hold_diff;
   logic [31:0]          dur_low;
   logic [3:0]           events;
   logic [3:0]           taken;
   logic                 status;
   logic                 rsp_both_edges;
   logic                 rsp_has_events;

   // advance when the result register is free or being emptied
   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // fit the timestamp and the duration to the time width
   generate
      if (TIME_BITS >= 32) begin : g_wide
         assign now_t   = TIME_BITS'(in_item.now_ms);
         assign dur_low = dur_in[31:0];
      end else begin : g_narrow
         assign now_t   = in_item.now_ms[TIME_BITS-1:0];
         assign dur_low = 32'(dur_in);
      end
   endgenerate

   assign db_t = TIME_BITS'(cfg.debounce_time);
   assign lp_t = TIME_BITS'(cfg.long_press_time);

   // polarity, bounce timer and hold timer
   assign raw       = cfg.low_pressed ? !in_item.pin_level : in_item.pin_level;
   assign raw_chg   = raw != last_raw_ff;
   assign chg_diff  = raw_chg ? '0 : now_t - change_ff;
   assign arm       = stable_ff && !timing_ff;
   assign start_eff = arm ? now_t : start_ff;
   assign hold_diff = now_t - start_eff;
   assign ld_eff    = arm ? 1'b0 : long_ff;
   assign flip      = (raw != stable_ff) && (chg_diff >= db_t);
   assign is_long   = hold_diff >= lp_t;

   // next state for one operation
   always_comb begin
      ready_in    = ready_ff;
      stable_in   = stable_ff;
      last_raw_in = last_raw_ff;
      timing_in   = timing_ff;
      long_in     = long_ff;
      change_in   = change_ff;
      start_in    = start_ff;
      dur_in      = dur_ff;
      pending_in  = pending_ff;
      events      = bdpc_pkg::EV_NONE;
      taken       = bdpc_pkg::EV_NONE;
      status      = bdpc_pkg::STATUS_OK;

      if (in_item.func == bdpc_pkg::FUNC_INIT) begin
         if (cfg.long_press_time == '0) begin
            status = bdpc_pkg::STATUS_NOT_INIT;
         end else begin
            ready_in    = 1'b1;
            stable_in   = raw;
            last_raw_in = raw;
            timing_in   = 1'b0;
            long_in     = 1'b0;
            change_in   = '0;
            start_in    = '0;
            dur_in      = '0;
            pending_in  = bdpc_pkg::EV_NONE;
         end
      end else if (!ready_ff) begin
         status = bdpc_pkg::STATUS_NOT_INIT;
      end else begin
         case (in_item.func)
            bdpc_pkg::FUNC_UPDATE: begin
               last_raw_in = raw;
               change_in   = raw_chg ? now_t : change_ff;
               if (!stable_ff) begin
                  // accepted press edge
                  if (flip) begin
                     stable_in = 1'b1;
                     timing_in = 1'b1;
                     start_in  = now_t;
                     dur_in    = '0;
                     long_in   = (lp_t == '0);
                     events    = bdpc_pkg::EV_PRESSED |
                                 ((lp_t == '0) ? bdpc_pkg::EV_LONG : bdpc_pkg::EV_NONE);
                  end
               end else begin
                  start_in = start_eff;
                  dur_in   = hold_diff;
                  long_in  = ld_eff || is_long;
                  if (flip) begin
                     // accepted release edge: classify the press
                     stable_in = 1'b0;
                     timing_in = 1'b0;
                     events    = bdpc_pkg::EV_RELEASED;
                     if (!ld_eff) begin
                        events = events | (is_long ? bdpc_pkg::EV_LONG : bdpc_pkg::EV_SHORT);
                     end
                  end else begin
                     // still held
                     timing_in = 1'b1;
                     if (!ld_eff && is_long) begin
                        events = bdpc_pkg::EV_LONG;
                     end
                  end
               end
               pending_in = pending_ff | events;
            end
            bdpc_pkg::FUNC_TAKE: begin
               taken      = pending_ff & in_item.take_mask;
               pending_in = pending_ff & ~taken;
            end
            default: begin
               status = bdpc_pkg::STATUS_OK;
            end
         endcase
      end
   end

   // build the result
   always_comb begin
      rsp_item_in.status          = status;
      rsp_item_in.is_pressed      = ready_in && stable_in;
      rsp_item_in.raw_pressed_now = raw;
      rsp_item_in.new_events      = events;
      rsp_item_in.pending_out     = ready_in ? pending_in : bdpc_pkg::EV_NONE;
      rsp_item_in.taken_events    = taken;
      rsp_item_in.hold_duration   = ready_in ? dur_low : 32'd0;
      rsp_valid_in                = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         stable_ff    <= 1'b0;
         last_raw_ff  <= 1'b0;
         timing_ff    <= 1'b0;
         long_ff      <= 1'b0;
         change_ff    <= '0;
         start_ff     <= '0;
         dur_ff       <= '0;
         pending_ff   <= bdpc_pkg::EV_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            ready_ff    <= ready_in;
            stable_ff   <= stable_in;
            last_raw_ff <= last_raw_in;
            timing_ff   <= timing_in;
            long_ff     <= long_in;
            change_ff   <= change_in;
            start_ff    <= start_in;
            dur_ff      <= dur_in;
            pending_ff  <= pending_in;
         end
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // flags on the held result beat
   assign rsp_both_edges = rsp_item_ff.new_events[0] && rsp_item_ff.new_events[1];
   assign rsp_has_events = (rsp_item_ff.new_events != bdpc_pkg::EV_NONE) ||
                           (rsp_item_ff.taken_events != bdpc_pkg::EV_NONE);

   `BDPC_ASSERT_ALWAYS(a_rsp_empty_after_reset, reset |=> !rsp_valid_ff, "result after reset")
   `BDPC_ASSERT(a_no_pending_before_init, !ready_ff |-> (pending_ff == 4'b0000), "pending while uninit")
   `BDPC_ASSERT(a_timing_only_pressed, timing_ff |-> stable_ff, "press timer runs while released")
   `BDPC_ASSERT(a_one_edge_per_tick, rsp_valid_ff |-> !rsp_both_edges, "press and release together")
   `BDPC_ASSERT(a_uninit_quiet, (rsp_valid_ff && rsp_item_ff.status) |-> !rsp_has_events, "events on failed step")

endmodule

[src/button_debounce_press_classifier.sv]
// Top level of the button debouncer and press classifier
//
// Channels: req_ch carries one operation per beat (update tick with pin
// sample and ms timestamp, take of pending events, or init), rsp_ch returns
// exactly one result beat per request beat, in order. csr_ch writes the
// debounce time, long press time and polarity; it is always ready. The user
// must write it only while no request is in flight; the block does not enforce it.
// Path: a request beat lands in the input register, then the result is
// computed from it and the debounce state and stored in the result
// register, which drives rsp_ch valid until the result beat is taken.
// Throughput: one beat per cycle while rsp_ch is ready, set by the single
// state update per cycle in the core.
// Reset: synchronous; configuration returns to 20 ms debounce, 1000 ms long
// press and active-low polarity, and the button reads as not initialized
// until an init beat.
// Stall: when rsp_ch is not ready, the result register holds its beat, the
// input register fills, and req_ch ready drops until the result is taken.
module button_debounce_press_classifier #(
   parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   bdpc_req_if.sink    req_ch,
   bdpc_rsp_if.source  rsp_ch,
   bdpc_csr_if.sink    csr_ch
);

   logic                   in_valid_ff, in_valid_in;
   bdpc_pkg::req_item_type in_item_ff;
   bdpc_pkg::req_item_type req_item;
   logic                   core_ready;
   logic                   req_fire;
   bdpc_pkg::cfg_type      cfg;
   bdpc_pkg::rsp_item_type rsp_item;

   // pack the request beat
   assign req_item.func      = req_ch.func;
   assign req_item.pin_level = req_ch.pin_level;
   assign req_item.now_ms    = req_ch.now_ms;
   assign req_item.take_mask = req_ch.take_mask;

   // accept while the input register is empty or moving on
   assign req_ch.ready = !in_valid_ff || core_ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !core_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
   end

   bdpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .wr_ready (csr_ch.ready),
      .cfg      (cfg)
   );

   bdpc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .in_ready  (core_ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (rsp_item)
   );

   // unpack the result beat
   assign rsp_ch.status          = rsp_item.status;
   assign rsp_ch.is_pressed      = rsp_item.is_pressed;
   assign rsp_ch.raw_pressed_now = rsp_item.raw_pressed_now;
   assign rsp_ch.new_events      = rsp_item.new_events;
   assign rsp_ch.pending_out     = rsp_item.pending_out;
   assign rsp_ch.taken_events    = rsp_item.taken_events;
   assign rsp_ch.hold_duration   = rsp_item.hold_duration;

endmodule

[dv/bdpc_press_checker.sv]
`timescale 1ns / 100ps
// Press classifier checker: predicts every result beat and compares it with the block
module bdpc_press_checker (
   input  logic clock,
   input  logic reset,
   bdpc_req_if  req_ch,
   bdpc_rsp_if  rsp_ch,
   bdpc_csr_if  csr_ch,
   output int   failure_count,
   output int   outstanding
);

   // predicted debounce and press state
   bdpc_pkg::cfg_type cfg;
   logic              btn_ready;
   logic              stable_pressed;
   logic              last_raw;
   logic              timing_on;
   logic              long_done;
   logic [31:0]       change_ms;
   logic [31:0]       start_ms;
   logic [31:0]       hold_ms;
   logic [3:0]        latched_events;

   bdpc_pkg::rsp_item_type expected_results[$];
   bdpc_pkg::rsp_item_type oldest;
   bdpc_pkg::req_item_type offered;

   // drop back to the not-initialized state
   function automatic void clear_press_state();
      btn_ready      = 1'b0;
      stable_pressed = 1'b0;
      last_raw       = 1'b0;
      timing_on      = 1'b0;
      long_done      = 1'b0;
      change_ms      = '0;
      start_ms       = '0;
      hold_ms        = '0;
      latched_events = bdpc_pkg::EV_NONE;
   endfunction

   // apply one request beat to the predicted state and build its result
   function automatic bdpc_pkg::rsp_item_type classify_beat(input bdpc_pkg::req_item_type beat);
      bdpc_pkg::rsp_item_type res;
      logic                   raw;
      logic                   status;
      logic [3:0]             fresh;
      logic [3:0]             taken;
      logic [31:0]            stable_for;

      raw    = cfg.low_pressed ? ~beat.pin_level : beat.pin_level;
      status = bdpc_pkg::STATUS_OK;
      fresh  = bdpc_pkg::EV_NONE;
      taken  = bdpc_pkg::EV_NONE;

      case (beat.func)
         bdpc_pkg::FUNC_INIT: begin
            // a zero long press time refuses the init and keeps the state
            if (cfg.long_press_time == '0) begin
               status = bdpc_pkg::STATUS_NOT_INIT;
            end else begin
               clear_press_state();
               btn_ready      = 1'b1;
               stable_pressed = raw;
               last_raw       = raw;
            end
         end
         bdpc_pkg::FUNC_UPDATE: begin
            if (!btn_ready) begin
               status = bdpc_pkg::STATUS_NOT_INIT;
            end else begin
               // a press held at init starts its timing on the first tick
               if (stable_pressed && !timing_on) begin
                  timing_on = 1'b1;
                  start_ms  = beat.now_ms;
                  hold_ms   = '0;
                  long_done = 1'b0;
               end
               if (raw != last_raw) begin
                  last_raw  = raw;
                  change_ms = beat.now_ms;
               end
               stable_for = beat.now_ms - change_ms;
               // follow the raw level once it has been stable long enough
               if (raw != stable_pressed && stable_for >= {16'd0, cfg.debounce_time}) begin
                  stable_pressed = raw;
                  if (raw) begin
                     timing_on = 1'b1;
                     long_done = 1'b0;
                     start_ms  = beat.now_ms;
                     hold_ms   = '0;
                     fresh     = fresh | bdpc_pkg::EV_PRESSED;
                  end else begin
                     if (timing_on)
                        hold_ms = beat.now_ms - start_ms;
                     fresh = fresh | bdpc_pkg::EV_RELEASED;
                     if (!long_done) begin
                        if (hold_ms >= {16'd0, cfg.long_press_time}) begin
                           fresh     = fresh | bdpc_pkg::EV_LONG;
                           long_done = 1'b1;
                        end else begin
                           fresh = fresh | bdpc_pkg::EV_SHORT;
                        end
                     end
                     timing_on = 1'b0;
                  end
               end
               // time the hold and raise the long press once
               if (stable_pressed && timing_on) begin
                  hold_ms = beat.now_ms - start_ms;
                  if (!long_done && hold_ms >= {16'd0, cfg.long_press_time}) begin
                     fresh     = fresh | bdpc_pkg::EV_LONG;
                     long_done = 1'b1;
                  end
               end
               latched_events = latched_events | fresh;
            end
         end
         bdpc_pkg::FUNC_TAKE: begin
            if (!btn_ready) begin
               status = bdpc_pkg::STATUS_NOT_INIT;
            end else begin
               taken          = latched_events & beat.take_mask;
               latched_events = latched_events & ~taken;
            end
         end
         default: begin
            if (!btn_ready)
               status = bdpc_pkg::STATUS_NOT_INIT;
         end
      endcase

      res.status          = status;
      res.is_pressed      = btn_ready & stable_pressed;
      res.raw_pressed_now = raw;
      res.new_events      = fresh;
      res.pending_out     = btn_ready ? latched_events : bdpc_pkg::EV_NONE;
      res.taken_events    = taken;
      res.hold_duration   = btn_ready ? hold_ms : '0;
      return res;
   endfunction

   // report one field that differs from its prediction
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         failure_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // watch the three channels on every rising edge
   always @(posedge clock) begin
      if (reset) begin
         cfg.debounce_time   = bdpc_pkg::DEBOUNCE_RESET;
         cfg.long_press_time = bdpc_pkg::LONG_PRESS_RESET;
         cfg.low_pressed     = bdpc_pkg::LOW_PRESSED_RESET;
         clear_press_state();
         expected_results.delete();
         failure_count = 0;
      end else begin
         // track register writes
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               bdpc_pkg::CSR_DEBOUNCE:    cfg.debounce_time   = csr_ch.data;
               bdpc_pkg::CSR_LONG_PRESS:  cfg.long_press_time = csr_ch.data;
               bdpc_pkg::CSR_LOW_PRESSED: cfg.low_pressed     = csr_ch.data[0];
               default: ;
            endcase
         end
         // predict each accepted request beat
         if (req_ch.valid && req_ch.ready) begin
            offered.func      = req_ch.func;
            offered.pin_level = req_ch.pin_level;
            offered.now_ms    = req_ch.now_ms;
            offered.take_mask = req_ch.take_mask;
            expected_results.push_back(classify_beat(offered));
         end
         // compare each accepted result beat with the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               failure_count++;
               $display("%0t: result beat with no prediction waiting, expected none, actual 0x%0h",
                        $time, rsp_ch.hold_duration);
            end else begin
               oldest = expected_results.pop_front();
               check_field("status", oldest.status, rsp_ch.status);
               check_field("is_pressed", oldest.is_pressed, rsp_ch.is_pressed);
               check_field("raw_pressed_now", oldest.raw_pressed_now, rsp_ch.raw_pressed_now);
               check_field("new_events", oldest.new_events, rsp_ch.new_events);
               check_field("pending_out", oldest.pending_out, rsp_ch.pending_out);
               check_field("taken_events", oldest.taken_events, rsp_ch.taken_events);
               check_field("hold_duration", oldest.hold_duration, rsp_ch.hold_duration);
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, button press stimulus and verdict for the press classifier
module testbench;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CHUNK_BEATS  = 230;
   localparam int NUM_CHUNKS   = 6;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock;
   logic reset;

   bdpc_req_if req_ch();
   bdpc_rsp_if rsp_ch();
   bdpc_csr_if csr_ch();

   int failure_count;
   int outstanding;
   int req_idle_pct;
   int rsp_idle_pct;
   int stall_orders;
   int stall_seen;
   int stall_left;
   int cycle_count;

   // settings as the stimulus sees them, and the button's timeline
   int unsigned            deb_ms;
   int unsigned            long_ms;
   logic                   alow;
   logic [31:0]            stamp;
   bdpc_pkg::req_item_type stimulus_q[$];

   button_debounce_press_classifier dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bdpc_press_checker press_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .failure_count (failure_count),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // end the run once it reaches the cycle limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("button_debounce_press_classifier verification failed");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      stall_seen   = 0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (stall_orders != stall_seen) begin
            stall_seen = stall_orders;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic push_beat(input logic [1:0] func, input logic pin, input logic [31:0] now,
                            input logic [3:0] mask);
      bdpc_pkg::req_item_type b;
      b.func      = func;
      b.pin_level = pin;
      b.now_ms    = now;
      b.take_mask = mask;
      stimulus_q.push_back(b);
   endtask

   // advance the timeline and sample the pin
   task automatic push_tick(input logic pressed, input int unsigned step);
      stamp = stamp + step;
      push_beat(bdpc_pkg::FUNC_UPDATE, pressed ^ alow, stamp, 4'($urandom_range(0, 15)));
   endtask

   task automatic push_take();
      push_beat(bdpc_pkg::FUNC_TAKE, 1'($urandom_range(0, 1)), $urandom,
                4'($urandom_range(0, 15)));
   endtask

   // hold one level for at least span ms, with an occasional take in between
   task automatic push_steady(input logic pressed, input int unsigned span);
      int unsigned n;
      int unsigned step;
      n    = $urandom_range(1, 6);
      step = span / n + 1;
      repeat (n + 1) begin
         if ($urandom_range(0, 9) == 0)
            push_take();
         push_tick(pressed, step);
      end
   endtask

   // contact bounce: up to four random levels, at most half the debounce time plus one ms apart
   task automatic push_bounce();
      repeat ($urandom_range(0, 4))
         push_tick(1'($urandom_range(0, 1)), $urandom_range(0, deb_ms / 2 + 1));
   endtask

   // mostly clean presses of random length, some takes, inits, unused operations, time jumps and noise
   task automatic build_episodes(input int count);
      int          kind;
      int unsigned hold;
      while (stimulus_q.size() < count) begin
         kind = $urandom_range(0, 19);
         if (kind < 14) begin
            if ($urandom_range(0, 1))
               hold = $urandom_range(0, long_ms);
            else
               hold = $urandom_range(long_ms, 2 * long_ms + 5);
            push_bounce();
            push_steady(1'b1, deb_ms + hold);
            push_bounce();
            push_steady(1'b0, deb_ms + $urandom_range(0, deb_ms + 10));
         end else case (kind)
            14, 15: push_take();
            16: push_beat(bdpc_pkg::FUNC_INIT, 1'($urandom_range(0, 1)), $urandom,
                          4'($urandom_range(0, 15)));
            17: push_beat(FUNC_UNUSED, 1'($urandom_range(0, 1)), $urandom,
                          4'($urandom_range(0, 15)));
            18: stamp = 32'hFFFF_FFFF - $urandom_range(0, 2 * deb_ms + long_ms);
            default: begin
               stamp = $urandom;
               repeat ($urandom_range(1, 4))
                  push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 2 * deb_ms + 2));
            end
         endcase
      end
   endtask

   // offer every queued beat, idling at random between beats
   task automatic drive_beats();
      foreach (stimulus_q[i]) begin
         while ($urandom_range(0, 99) < req_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clock);
         end
         req_ch.valid     = 1'b1;
         req_ch.func      = stimulus_q[i].func;
         req_ch.pin_level = stimulus_q[i].pin_level;
         req_ch.now_ms    = stimulus_q[i].now_ms;
         req_ch.take_mask = stimulus_q[i].take_mask;
         do
            @(posedge clock);
         while (!req_ch.ready);
         @(negedge clock);
      end
      req_ch.valid = 1'b0;
      stimulus_q.delete();
   endtask

   // wait for every predicted result, then let the pipeline settle
   task automatic wait_drained();
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bdpc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [bdpc_pkg::CSR_DATA_BITS-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      @(negedge clock);
   endtask

   // write all three registers while the block is idle
   task automatic apply_settings(input logic [15:0] d, input logic [15:0] l, input logic a);
      wait_drained();
      write_csr(bdpc_pkg::CSR_DEBOUNCE, d);
      write_csr(bdpc_pkg::CSR_LONG_PRESS, l);
      write_csr(bdpc_pkg::CSR_LOW_PRESSED, {15'($urandom), a});
      csr_ch.valid = 1'b0;
      deb_ms  = 32'(d);
      long_ms = 32'(l);
      alow    = a;
   endtask

   initial begin
      int chunk;
      req_ch.valid     = 1'b0;
      req_ch.func      = bdpc_pkg::FUNC_UPDATE;
      req_ch.pin_level = 1'b0;
      req_ch.now_ms    = '0;
      req_ch.take_mask = bdpc_pkg::EV_NONE;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = bdpc_pkg::CSR_DEBOUNCE;
      csr_ch.data      = '0;
      reset            = 1'b1;
      stamp            = '0;
      deb_ms           = 32'(bdpc_pkg::DEBOUNCE_RESET);
      long_ms          = 32'(bdpc_pkg::LONG_PRESS_RESET);
      alow             = bdpc_pkg::LOW_PRESSED_RESET;
      req_idle_pct     = 26;
      rsp_idle_pct     = 88;
      stall_orders     = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // not initialized, held at init, long then release, short press
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'hFFFF_FFFF, 4'hF);
      push_beat(bdpc_pkg::FUNC_TAKE, 1'b1, 32'h0, 4'hF);
      push_beat(FUNC_UNUSED, 1'b1, 32'h0, 4'h0);
      push_beat(bdpc_pkg::FUNC_INIT, 1'b0, 32'h0, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'd100, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'd1200, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b1, 32'd1210, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b1, 32'd1230, 4'h0);
      push_beat(bdpc_pkg::FUNC_TAKE, 1'b1, 32'd1230,
                bdpc_pkg::EV_PRESSED | bdpc_pkg::EV_SHORT);
      push_beat(FUNC_UNUSED, 1'b0, 32'd1230, 4'hF);
      push_beat(bdpc_pkg::FUNC_TAKE, 1'b1, 32'd1230, 4'hF);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'd1240, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'd1260, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b1, 32'd1270, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b1, 32'd1290, 4'h0);
      push_beat(bdpc_pkg::FUNC_INIT, 1'b1, 32'd1290, 4'h0);
      drive_beats();

      // zero long press time: init refused, any hold is long, time wraps
      apply_settings(16'd0, 16'd0, 1'b0);
      push_beat(bdpc_pkg::FUNC_INIT, 1'b1, 32'h0, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b1, 32'hFFFF_FFF0, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'h0000_0005, 4'h0);
      push_beat(bdpc_pkg::FUNC_TAKE, 1'b0, 32'h0, 4'hF);
      drive_beats();

      // longest debounce, shortest long press
      apply_settings(16'hFFFF, 16'd1, 1'b1);
      push_beat(bdpc_pkg::FUNC_INIT, 1'b1, 32'h0, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'd10, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'd65544, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b0, 32'd65545, 4'h0);
      push_beat(bdpc_pkg::FUNC_UPDATE, 1'b1, 32'd65546, 4'h0);
      drive_beats();

      // random presses under several settings and idling patterns
      for (chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
         if (chunk < 2) begin
            req_idle_pct = 26;
            rsp_idle_pct = 88;
         end else if (chunk < 4) begin
            req_idle_pct = 88;
            rsp_idle_pct = 26;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (chunk)
            0: apply_settings(16'd20, 16'd1000, 1'b1);
            1: apply_settings(16'd0, 16'd1, 1'b0);
            2: apply_settings(16'hFFFF, 16'hFFFF, 1'b1);
            3: apply_settings(16'd3, 16'd40, 1'b0);
            4: apply_settings(16'($urandom_range(0, 200)), 16'($urandom_range(1, 3000)),
                              1'($urandom_range(0, 1)));
            default: apply_settings(16'd1, 16'hFFFF, 1'b1);
         endcase
         push_beat(bdpc_pkg::FUNC_INIT, alow, stamp, bdpc_pkg::EV_NONE);
         build_episodes(CHUNK_BEATS);
         // hold off the result side while requests keep coming
         if (chunk == 4)
            stall_orders++;
         drive_beats();
      end

      wait_drained();
      if (failure_count == 0 && outstanding == 0)
         $display("button_debounce_press_classifier verification clean");
      else
         $display("button_debounce_press_classifier verification failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/bdpc_pkg.sv
src/bdpc_req_if.sv
src/bdpc_rsp_if.sv
src/bdpc_csr_if.sv
src/bdpc_csr.sv
src/bdpc_core.sv
src/button_debounce_press_classifier.sv
dv/bdpc_press_checker.sv
dv/testbench.sv
